>>> hw/rtl/blob_track_click_drag_classifier_core_defines.svh
// Assertion macros used by the checker file of the blob tracker.
`ifndef BLOB_TRACK_CLICK_DRAG_CLASSIFIER_CORE_DEFINES_SVH
`define BLOB_TRACK_CLICK_DRAG_CLASSIFIER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BTCD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define BTCD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/btcd_pkg.sv
// ----------------------------------------------------------------------------
// btcd_pkg
// Shared types, codes and widths of the blob tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package btcd_pkg;

	localparam int DEF_RECORD_COUNT  = 16;
	localparam int DEF_CONFIRM_LEVEL = 5;

	localparam int CONF_W = 3;
	localparam int POS_W  = 16;
	localparam int EXP_W  = 18;
	localparam int R_W    = 17;
	localparam int R2_W   = 34;
	localparam int D2_W   = 35;
	localparam int ID_W   = 16;
	localparam int CLS_W  = 8;

	localparam logic [R_W-1:0] CLICK_RADIUS_RST = 17'd4588;
	localparam logic [R_W-1:0] DRAG_RADIUS_RST  = 17'd9830;

	localparam logic [1:0] KIND_CLICK     = 2'd0;
	localparam logic [1:0] KIND_DRAG_NEW  = 2'd1;
	localparam logic [1:0] KIND_DRAG_CONT = 2'd2;
	localparam logic [1:0] KIND_DRAG_OFF  = 2'd3;

	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_POINT = 2'd1;
	localparam logic [1:0] CMD_END   = 2'd2;

	localparam logic CFG_CLICK = 1'b0;

	localparam logic [2:0] OP_NONE    = 3'd0;
	localparam logic [2:0] OP_START   = 3'd1;
	localparam logic [2:0] OP_CALC    = 3'd2;
	localparam logic [2:0] OP_DECAY   = 3'd3;
	localparam logic [2:0] OP_BUMP    = 3'd4;
	localparam logic [2:0] OP_TODRAG  = 3'd5;
	localparam logic [2:0] OP_DRAGUPD = 3'd6;
	localparam logic [2:0] OP_OPEN    = 3'd7;

	typedef struct packed {
		logic [2:0]       op;
		logic [POS_W-1:0] px;
		logic [POS_W-1:0] py;
		logic [CLS_W-1:0] cls;
		logic [ID_W-1:0]  ident;
		logic [1:0]       open_kind;
	} bus_t;

	typedef struct packed {
		logic [ID_W-1:0]   ident;
		logic [1:0]        kind;
		logic [POS_W-1:0]  cur_x;
		logic [POS_W-1:0]  cur_y;
		logic [POS_W-1:0]  org_x;
		logic [POS_W-1:0]  org_y;
		logic [CLS_W-1:0]  cls;
		logic [CONF_W-1:0] conf;
	} rec_t;

endpackage

>>> hw/rtl/btcd_cell.sv
// ----------------------------------------------------------------------------
// btcd_cell
// One track record: holds its state, computes its distance to the point and
// passes the running nearest and first-free search on to the next cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module btcd_cell #(
	parameter int RECORD_COUNT  = 16,
	parameter int CONFIRM_LEVEL = 5,
	localparam int IDX_W = (RECORD_COUNT > 1) ? $clog2(RECORD_COUNT) : 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [IDX_W-1:0]          my_idx,
	input  btcd_pkg::bus_t            bus,
	input  logic [IDX_W-1:0]          sel_idx,
	input  logic                      tin_found,
	input  logic [btcd_pkg::D2_W-1:0] tin_best,
	input  logic [IDX_W-1:0]          tin_idx,
	input  logic [1:0]                tin_kind,
	input  logic                      tin_free_found,
	input  logic [IDX_W-1:0]          tin_free_idx,
	output logic                      tout_found,
	output logic [btcd_pkg::D2_W-1:0] tout_best,
	output logic [IDX_W-1:0]          tout_idx,
	output logic [1:0]                tout_kind,
	output logic                      tout_free_found,
	output logic [IDX_W-1:0]          tout_free_idx,
	output btcd_pkg::rec_t            rec,
	output logic                      emit
);
	import btcd_pkg::*;

	logic [CONF_W-1:0] conf_q;
	logic              valid_q;
	logic              handled_q;
	logic [1:0]        kind_q;
	logic [ID_W-1:0]   ident_q;
	logic [POS_W-1:0]  org_x_q, org_y_q, cur_x_q, cur_y_q;
	logic [EXP_W-1:0]  exp_x_q, exp_y_q;
	logic [CLS_W-1:0]  cls_q;
	logic [D2_W-1:0]   d2_q;
	logic              emit_q;

	logic              sel, cand, take, take_free;
	logic [EXP_W:0]    dx, dy, ax, ay;
	logic [R2_W-1:0]   sqx, sqy;
	logic [D2_W-1:0]   d2;
	logic [CONF_W-1:0] conf_bump, conf_dec;
	logic              valid_bump;
	logic [EXP_W:0]    ex_new, ey_new;

	assign sel = (sel_idx == my_idx);

	// distance from the expected position, exact
	assign dx  = {exp_x_q[EXP_W-1], exp_x_q} - {3'b000, bus.px};
	assign dy  = {exp_y_q[EXP_W-1], exp_y_q} - {3'b000, bus.py};
	assign ax  = dx[EXP_W] ? -dx : dx;
	assign ay  = dy[EXP_W] ? -dy : dy;
	assign sqx = ax[R_W-1:0] * ax[R_W-1:0];
	assign sqy = ay[R_W-1:0] * ay[R_W-1:0];
	assign d2  = {1'b0, sqx} + {1'b0, sqy};

	assign cand      = (conf_q != '0) && !handled_q;
	assign take      = cand && (!tin_found || (d2_q < tin_best));
	assign take_free = !tin_free_found && (conf_q == '0);

	assign conf_bump  = (conf_q < CONF_W'(CONFIRM_LEVEL)) ? conf_q + 1'b1 : conf_q;
	assign valid_bump = valid_q || (conf_bump == CONF_W'(CONFIRM_LEVEL));
	assign conf_dec   = conf_q - 1'b1;

	// extrapolate: 2*point - old current
	assign ex_new = {2'b00, bus.px, 1'b0} - {3'b000, cur_x_q};
	assign ey_new = {2'b00, bus.py, 1'b0} - {3'b000, cur_y_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tout_found      <= 1'b0;
			tout_free_found <= 1'b0;
		end else begin
			tout_found      <= tin_found || take;
			tout_free_found <= tin_free_found || take_free;
		end
	end

	always_ff @(posedge clk) begin
		tout_best     <= take ? d2_q : tin_best;
		tout_idx      <= take ? my_idx : tin_idx;
		tout_kind     <= take ? kind_q : tin_kind;
		tout_free_idx <= take_free ? my_idx : tin_free_idx;
		if (bus.op == OP_CALC) begin
			d2_q <= d2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conf_q    <= '0;
			valid_q   <= 1'b0;
			handled_q <= 1'b0;
			kind_q    <= KIND_CLICK;
			ident_q   <= '0;
			org_x_q   <= '0;
			org_y_q   <= '0;
			cur_x_q   <= '0;
			cur_y_q   <= '0;
			exp_x_q   <= '0;
			exp_y_q   <= '0;
			cls_q     <= '0;
			emit_q    <= 1'b0;
		end else begin
			case (bus.op)
				OP_START: begin
					handled_q <= 1'b0;
					if (valid_q && kind_q == KIND_DRAG_NEW) begin
						kind_q <= KIND_DRAG_CONT;
					end
				end
				OP_DECAY: begin
					emit_q <= (conf_q != '0) && valid_q;
					if (cand) begin
						conf_q <= conf_dec;
						if (conf_dec == '0 && kind_q == KIND_DRAG_CONT) begin
							kind_q <= KIND_DRAG_OFF;
						end
					end
				end
				OP_BUMP: begin
					if (sel) begin
						conf_q    <= conf_bump;
						valid_q   <= valid_bump;
						handled_q <= 1'b1;
					end
				end
				OP_TODRAG: begin
					if (sel) begin
						conf_q    <= conf_bump;
						valid_q   <= valid_bump;
						handled_q <= 1'b1;
						kind_q    <= KIND_DRAG_NEW;
						org_x_q   <= bus.px;
						org_y_q   <= bus.py;
						cur_x_q   <= bus.px;
						cur_y_q   <= bus.py;
						exp_x_q   <= {2'b00, bus.px};
						exp_y_q   <= {2'b00, bus.py};
					end
				end
				OP_DRAGUPD: begin
					if (sel) begin
						conf_q    <= conf_bump;
						valid_q   <= valid_bump;
						handled_q <= 1'b1;
						org_x_q   <= cur_x_q;
						org_y_q   <= cur_y_q;
						cur_x_q   <= bus.px;
						cur_y_q   <= bus.py;
						exp_x_q   <= ex_new[EXP_W-1:0];
						exp_y_q   <= ey_new[EXP_W-1:0];
					end
				end
				OP_OPEN: begin
					if (sel) begin
						conf_q    <= CONF_W'(1);
						valid_q   <= 1'b0;
						handled_q <= 1'b1;
						kind_q    <= bus.open_kind;
						ident_q   <= bus.ident;
						org_x_q   <= bus.px;
						org_y_q   <= bus.py;
						cur_x_q   <= bus.px;
						cur_y_q   <= bus.py;
						exp_x_q   <= {2'b00, bus.px};
						exp_y_q   <= {2'b00, bus.py};
						cls_q     <= bus.cls;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign rec = '{ident: ident_q, kind: kind_q, cur_x: cur_x_q, cur_y: cur_y_q,
		org_x: org_x_q, org_y: org_y_q, cls: cls_q, conf: conf_q};
	assign emit = emit_q;

endmodule

>>> hw/rtl/blob_track_click_drag_classifier_core.sv
// ----------------------------------------------------------------------------
// blob_track_click_drag_classifier_core
// Nearest-neighbour blob tracker with click / drag classification.
// Frame start: the start state, then back to idle. Point: the calc, scan,
// decide and apply states, the scan walking the search one cell a cycle.
// Frame end: the decay state, then a walk over the records up to the last
// reported one, one result per cycle when the sink is ready. Reset clears
// every record at once; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module blob_track_click_drag_classifier_core #(
	parameter int RECORD_COUNT  = btcd_pkg::DEF_RECORD_COUNT,
	parameter int CONFIRM_LEVEL = btcd_pkg::DEF_CONFIRM_LEVEL
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  command,
	input  logic [btcd_pkg::POS_W-1:0]  point_x,
	input  logic [btcd_pkg::POS_W-1:0]  point_y,
	input  logic [btcd_pkg::CLS_W-1:0]  blob_class,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        present,
	output logic                        last,
	output logic [btcd_pkg::ID_W-1:0]   track_id,
	output logic [1:0]                  event_kind,
	output logic [btcd_pkg::POS_W-1:0]  current_x,
	output logic [btcd_pkg::POS_W-1:0]  current_y,
	output logic [btcd_pkg::POS_W-1:0]  start_x,
	output logic [btcd_pkg::POS_W-1:0]  start_y,
	output logic [btcd_pkg::CLS_W-1:0]  track_class,
	output logic [btcd_pkg::CONF_W-1:0] track_confidence,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic                        cfg_index,
	input  logic [btcd_pkg::R_W-1:0]    cfg_data
);
	import btcd_pkg::*;

	localparam int IDX_W = (RECORD_COUNT > 1) ? $clog2(RECORD_COUNT) : 1;

	// sequencer codes
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_ONE    = 3'd1;
	localparam logic [2:0] S_CALC   = 3'd2;
	localparam logic [2:0] S_SCAN   = 3'd3;
	localparam logic [2:0] S_DECIDE = 3'd4;
	localparam logic [2:0] S_APPLY  = 3'd5;
	localparam logic [2:0] S_DECAY  = 3'd6;
	localparam logic [2:0] S_EMIT   = 3'd7;

	logic [2:0]       state_q;
	logic [IDX_W-1:0] cnt_q;
	logic [1:0]       cmd_q;
	logic [POS_W-1:0] px_q, py_q;
	logic [CLS_W-1:0] cls_q;
	logic [ID_W-1:0]  next_ident_q;
	logic [2:0]       act_op_q;
	logic [IDX_W-1:0] act_idx_q;

	logic [R_W-1:0]  click_radius_q, drag_radius_q;
	logic [R2_W-1:0] rc2_q, rd2_q;

	logic            out_valid_q;
	rec_t            out_rec_q;
	logic            present_q, last_q;

	bus_t            bus;
	logic [2:0]      bus_op;

	// search chain: entry 0 is the empty search fed into the first cell
	logic            tok_found      [RECORD_COUNT+1];
	logic [D2_W-1:0] tok_best       [RECORD_COUNT+1];
	logic [IDX_W-1:0] tok_idx       [RECORD_COUNT+1];
	logic [1:0]      tok_kind       [RECORD_COUNT+1];
	logic            tok_free_found [RECORD_COUNT+1];
	logic [IDX_W-1:0] tok_free_idx  [RECORD_COUNT+1];

	rec_t                    recs [RECORD_COUNT];
	logic [RECORD_COUNT-1:0] emit_mask;

	logic [RECORD_COUNT-1:0] above;
	logic                    out_free, emit_none, cur_flag, ld_empty, ld_rec;
	logic                    in_xfer;
	logic [D2_W-1:0]         best, rc2, rd2;
	logic [2:0]              dec_op;
	logic [IDX_W-1:0]        dec_idx;

	assign tok_found[0]      = 1'b0;
	assign tok_best[0]       = '0;
	assign tok_idx[0]        = '0;
	assign tok_kind[0]       = KIND_CLICK;
	assign tok_free_found[0] = 1'b0;
	assign tok_free_idx[0]   = '0;

	// broadcast to all cells
	always_comb begin
		case (state_q)
			S_ONE:   bus_op = (cmd_q == CMD_START) ? OP_START : OP_NONE;
			S_CALC:  bus_op = OP_CALC;
			S_APPLY: bus_op = act_op_q;
			S_DECAY: bus_op = OP_DECAY;
			default: bus_op = OP_NONE;
		endcase
	end

	assign bus = '{op: bus_op, px: px_q, py: py_q, cls: cls_q,
		ident: next_ident_q + 1'b1,
		open_kind: (click_radius_q == '0) ? KIND_DRAG_NEW : KIND_CLICK};

	genvar g;
	generate
		for (g = 0; g < RECORD_COUNT; g++) begin : g_cell
			btcd_cell #(
				.RECORD_COUNT  (RECORD_COUNT),
				.CONFIRM_LEVEL (CONFIRM_LEVEL)
			) u_cell (
				.clk             (clk),
				.arst_n          (arst_n),
				.my_idx          (IDX_W'(g)),
				.bus             (bus),
				.sel_idx         (act_idx_q),
				.tin_found       (tok_found[g]),
				.tin_best        (tok_best[g]),
				.tin_idx         (tok_idx[g]),
				.tin_kind        (tok_kind[g]),
				.tin_free_found  (tok_free_found[g]),
				.tin_free_idx    (tok_free_idx[g]),
				.tout_found      (tok_found[g+1]),
				.tout_best       (tok_best[g+1]),
				.tout_idx        (tok_idx[g+1]),
				.tout_kind       (tok_kind[g+1]),
				.tout_free_found (tok_free_found[g+1]),
				.tout_free_idx   (tok_free_idx[g+1]),
				.rec             (recs[g]),
				.emit            (emit_mask[g])
			);
		end
	endgenerate

	// match decision on the search result leaving the last cell
	assign best = tok_best[RECORD_COUNT];
	assign rc2  = {1'b0, rc2_q};
	assign rd2  = {1'b0, rd2_q};

	always_comb begin
		dec_op  = OP_NONE;
		dec_idx = tok_idx[RECORD_COUNT];
		if (tok_found[RECORD_COUNT]) begin
			case (tok_kind[RECORD_COUNT])
				KIND_CLICK: begin
					if (best < rc2) begin
						dec_op = OP_BUMP;
					end else if (best > rc2 && best < rd2) begin
						dec_op = OP_TODRAG;
					end
				end
				KIND_DRAG_NEW, KIND_DRAG_CONT: begin
					if (best < rd2) begin
						dec_op = OP_DRAGUPD;
					end
				end
				default: begin
				end
			endcase
		end
		// no match: open the lowest free record, drop if the table is full
		if (dec_op == OP_NONE && tok_free_found[RECORD_COUNT]) begin
			dec_op  = OP_OPEN;
			dec_idx = tok_free_idx[RECORD_COUNT];
		end
	end

	// frame-end readout: walk records in index order
	assign out_free  = !out_valid_q || out_ready;
	assign emit_none = (emit_mask == '0);
	assign cur_flag  = emit_mask[cnt_q];
	assign above     = emit_mask & ~((RECORD_COUNT'(2) << cnt_q) - RECORD_COUNT'(1));
	assign ld_empty  = (state_q == S_EMIT) && out_free && emit_none;
	assign ld_rec    = (state_q == S_EMIT) && out_free && !emit_none && cur_flag;

	assign in_ready  = (state_q == S_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			next_ident_q <= '0;
			act_op_q     <= OP_NONE;
			act_idx_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (in_xfer) begin
						case (command)
							CMD_POINT: state_q <= S_CALC;
							CMD_END:   state_q <= S_DECAY;
							default:   state_q <= S_ONE;
						endcase
					end
				end
				S_ONE:  state_q <= S_IDLE;
				S_CALC: state_q <= S_SCAN;
				S_SCAN: begin
					// wait for the search to pass every cell
					if (cnt_q == IDX_W'(RECORD_COUNT - 1)) begin
						state_q <= S_DECIDE;
					end
					cnt_q <= cnt_q + 1'b1;
				end
				S_DECIDE: begin
					act_op_q  <= dec_op;
					act_idx_q <= dec_idx;
					state_q   <= S_APPLY;
				end
				S_APPLY: begin
					if (act_op_q == OP_OPEN) begin
						next_ident_q <= next_ident_q + 1'b1;
					end
					state_q <= S_IDLE;
				end
				S_DECAY: begin
					cnt_q   <= '0;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (ld_empty) begin
						state_q <= S_IDLE;
					end else if (ld_rec) begin
						if (above == '0) begin
							state_q <= S_IDLE;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end else if (!emit_none && !cur_flag) begin
						// skip records that emit nothing
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// hold the item once taken
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cmd_q <= command;
			px_q  <= point_x;
			py_q  <= point_y;
			cls_q <= blob_class;
		end
	end

	// radii and their squares
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			click_radius_q <= CLICK_RADIUS_RST;
			drag_radius_q  <= DRAG_RADIUS_RST;
			rc2_q          <= R2_W'(CLICK_RADIUS_RST) * R2_W'(CLICK_RADIUS_RST);
			rd2_q          <= R2_W'(DRAG_RADIUS_RST) * R2_W'(DRAG_RADIUS_RST);
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_CLICK) begin
					click_radius_q <= cfg_data;
				end else begin
					drag_radius_q <= cfg_data;
				end
			end
			rc2_q <= click_radius_q * click_radius_q;
			rd2_q <= drag_radius_q * drag_radius_q;
		end
	end

	// output register: the sink may stall while the walk waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld_empty || ld_rec) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_empty) begin
			out_rec_q <= '0;
			present_q <= 1'b0;
			last_q    <= 1'b1;
		end else if (ld_rec) begin
			out_rec_q <= recs[cnt_q];
			present_q <= 1'b1;
			last_q    <= (above == '0);
		end
	end

	assign out_valid        = out_valid_q;
	assign present          = present_q;
	assign last             = last_q;
	assign track_id         = out_rec_q.ident;
	assign event_kind       = out_rec_q.kind;
	assign current_x        = out_rec_q.cur_x;
	assign current_y        = out_rec_q.cur_y;
	assign start_x          = out_rec_q.org_x;
	assign start_y          = out_rec_q.org_y;
	assign track_class      = out_rec_q.cls;
	assign track_confidence = out_rec_q.conf;

endmodule

>>> hw/rtl/btcd_checker.sv
// ----------------------------------------------------------------------------
// btcd_checker
// Port-level checks on the blob tracker, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "blob_track_click_drag_classifier_core_defines.svh"

module btcd_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic                        present,
	input logic                        last,
	input logic [btcd_pkg::ID_W-1:0]   track_id,
	input logic [1:0]                  event_kind,
	input logic [btcd_pkg::CONF_W-1:0] track_confidence
);
	import btcd_pkg::*;

	`BTCD_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
	`BTCD_ASSERT_IMP(a_empty_last, out_valid && !present, last, "empty result not last")
	`BTCD_ASSERT_IMP(a_empty_zero, out_valid && !present, track_id == '0 && event_kind == KIND_CLICK && track_confidence == '0, "empty result not zero")
	`BTCD_ASSERT_NXT(a_busy, in_valid && in_ready, !in_ready, "input taken while busy")

endmodule

bind blob_track_click_drag_classifier_core btcd_checker u_btcd_checker (.*);

>>> bench/blob_track_click_drag_classifier_core_tb.sv
// ----------------------------------------------------------------------------
// blob_track_click_drag_classifier_core_tb
// Self-checking bench for the blob tracker: drives frames of point items with
// random idling on both sides, predicts every frame-end report in a scoreboard
// class and compares each result transfer field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Tracker prediction and the queue of expected reports.
class track_scoreboard;
	localparam int NREC = btcd_pkg::DEF_RECORD_COUNT;
	localparam int CONF_MAX = btcd_pkg::DEF_CONFIRM_LEVEL;

	typedef struct packed {
		logic        present;
		logic        last;
		logic [15:0] track_id;
		logic [1:0]  event_kind;
		logic [15:0] current_x;
		logic [15:0] current_y;
		logic [15:0] start_x;
		logic [15:0] start_y;
		logic [7:0]  track_class;
		logic [2:0]  track_confidence;
	} report_t;

	bit [16:0] click_r, drag_r;
	bit [2:0]  conf [NREC];
	bit        valid [NREC];
	bit        handled [NREC];
	bit [1:0]  kind [NREC];
	bit [15:0] ident [NREC];
	bit [15:0] org_x [NREC], org_y [NREC], cur_x [NREC], cur_y [NREC];
	int        exp_x [NREC], exp_y [NREC];
	bit [7:0]  cls [NREC];
	bit [15:0] last_ident;
	report_t   pending_reports [$];
	int        errors;
	int        reports_seen;

	function new();
		click_r = btcd_pkg::CLICK_RADIUS_RST;
		drag_r = btcd_pkg::DRAG_RADIUS_RST;
		last_ident = 0;
		errors = 0;
		reports_seen = 0;
		for (int r = 0; r < NREC; r++) begin
			conf[r] = 0; valid[r] = 0; handled[r] = 0; kind[r] = btcd_pkg::KIND_CLICK;
			ident[r] = 0; org_x[r] = 0; org_y[r] = 0; cur_x[r] = 0; cur_y[r] = 0;
			exp_x[r] = 0; exp_y[r] = 0; cls[r] = 0;
		end
	endfunction

	function void note_config(bit idx, bit [16:0] data);
		if (idx == btcd_pkg::CFG_CLICK)
			click_r = data;
		else
			drag_r = data;
	endfunction

	// Append one expected report at the tail of the queue.
	function void enqueue_report(report_t rp);
		pending_reports = {pending_reports, rp};
	endfunction

	function longint sq(int a, int b);
		longint d;
		d = longint'(a) - longint'(b);
		return d * d;
	endfunction

	function void track_point(bit [15:0] px, bit [15:0] py, bit [7:0] c);
		longint best, d2, rc2, rd2;
		int bi, fr;
		bit hit;
		best = 0; bi = NREC; hit = 0; fr = NREC;
		rc2 = longint'(click_r) * click_r;
		rd2 = longint'(drag_r) * drag_r;
		for (int r = 0; r < NREC; r++) begin
			if (conf[r] == 0 || handled[r])
				continue;
			d2 = sq(exp_x[r], px) + sq(exp_y[r], py);
			if (bi == NREC || d2 < best) begin
				best = d2;
				bi = r;
			end
		end
		if (bi < NREC) begin
			if (kind[bi] == btcd_pkg::KIND_CLICK) begin
				if (best < rc2)
					hit = 1;
				else if (best > rc2 && best < rd2) begin
					kind[bi] = btcd_pkg::KIND_DRAG_NEW;
					cur_x[bi] = px; org_x[bi] = px; cur_y[bi] = py; org_y[bi] = py;
					exp_x[bi] = px; exp_y[bi] = py;
					hit = 1;
				end
			end else if (kind[bi] != btcd_pkg::KIND_DRAG_OFF && best < rd2) begin
				org_x[bi] = cur_x[bi]; org_y[bi] = cur_y[bi];
				cur_x[bi] = px; cur_y[bi] = py;
				exp_x[bi] = 2 * int'(px) - int'(org_x[bi]);
				exp_y[bi] = 2 * int'(py) - int'(org_y[bi]);
				hit = 1;
			end
			if (hit) begin
				if (conf[bi] < CONF_MAX) begin
					conf[bi]++;
					if (conf[bi] == CONF_MAX)
						valid[bi] = 1;
				end
				handled[bi] = 1;
				return;
			end
		end
		for (int r = NREC - 1; r >= 0; r--)
			if (conf[r] == 0)
				fr = r;
		if (fr == NREC)
			return;
		last_ident++;
		ident[fr] = last_ident; valid[fr] = 0; conf[fr] = 1; handled[fr] = 1;
		org_x[fr] = px; cur_x[fr] = px; org_y[fr] = py; cur_y[fr] = py;
		exp_x[fr] = px; exp_y[fr] = py;
		kind[fr] = (click_r == 0) ? btcd_pkg::KIND_DRAG_NEW : btcd_pkg::KIND_CLICK;
		cls[fr] = c;
	endfunction

	// Note one accepted input transfer and queue the reports it causes.
	function void note_input(bit [1:0] cmd, bit [15:0] px, bit [15:0] py, bit [7:0] c);
		int n;
		report_t rp;
		n = 0;
		if (cmd == btcd_pkg::CMD_START) begin
			for (int r = 0; r < NREC; r++) begin
				handled[r] = 0;
				if (valid[r] && kind[r] == btcd_pkg::KIND_DRAG_NEW)
					kind[r] = btcd_pkg::KIND_DRAG_CONT;
			end
		end else if (cmd == btcd_pkg::CMD_POINT) begin
			track_point(px, py, c);
		end else if (cmd == btcd_pkg::CMD_END) begin
			for (int r = 0; r < NREC; r++) begin
				if (conf[r] == 0)
					continue;
				if (!handled[r]) begin
					conf[r]--;
					if (conf[r] == 0 && kind[r] == btcd_pkg::KIND_DRAG_CONT)
						kind[r] = btcd_pkg::KIND_DRAG_OFF;
				end
				if (!valid[r])
					continue;
				rp = '{1'b1, 1'b0, ident[r], kind[r], cur_x[r], cur_y[r], org_x[r],
					org_y[r], cls[r], conf[r]};
				enqueue_report(rp);
				n++;
			end
			if (n == 0) begin
				rp = '0;
				rp.last = 1;
				enqueue_report(rp);
			end else
				pending_reports[pending_reports.size() - 1].last = 1;
		end
	endfunction

	// Check one accepted result transfer against the oldest expectation.
	function void check_report(report_t got);
		report_t w;
		reports_seen++;
		if (pending_reports.size() == 0) begin
			$error("unexpected result transfer");
			errors++;
			return;
		end
		w = pending_reports.pop_front();
		if (got.present !== w.present) begin
			$error("present exp %0d got %0d", w.present, got.present); errors++; end
		if (got.last !== w.last) begin
			$error("last exp %0d got %0d", w.last, got.last); errors++; end
		if (got.track_id !== w.track_id) begin
			$error("track_id exp %0d got %0d", w.track_id, got.track_id); errors++; end
		if (got.event_kind !== w.event_kind) begin
			$error("event_kind exp %0d got %0d", w.event_kind, got.event_kind); errors++; end
		if (got.current_x !== w.current_x) begin
			$error("current_x exp %0d got %0d", w.current_x, got.current_x); errors++; end
		if (got.current_y !== w.current_y) begin
			$error("current_y exp %0d got %0d", w.current_y, got.current_y); errors++; end
		if (got.start_x !== w.start_x) begin
			$error("start_x exp %0d got %0d", w.start_x, got.start_x); errors++; end
		if (got.start_y !== w.start_y) begin
			$error("start_y exp %0d got %0d", w.start_y, got.start_y); errors++; end
		if (got.track_class !== w.track_class) begin
			$error("track_class exp %0d got %0d", w.track_class, got.track_class); errors++; end
		if (got.track_confidence !== w.track_confidence) begin
			$error("track_confidence exp %0d got %0d", w.track_confidence,
				got.track_confidence);
			errors++;
		end
	endfunction
endclass

module blob_track_click_drag_classifier_core_tb;
	import btcd_pkg::*;

	logic              clk = 0;
	logic              arst_n = 0;
	logic              in_valid = 0;
	logic              in_ready;
	logic [1:0]        command = CMD_START;
	logic [POS_W-1:0]  point_x = 0;
	logic [POS_W-1:0]  point_y = 0;
	logic [CLS_W-1:0]  blob_class = 0;
	logic              out_valid;
	logic              out_ready = 0;
	logic              present, last;
	logic [ID_W-1:0]   track_id;
	logic [1:0]        event_kind;
	logic [POS_W-1:0]  current_x, current_y, start_x, start_y;
	logic [CLS_W-1:0]  track_class;
	logic [CONF_W-1:0] track_confidence;
	logic              cfg_valid = 0;
	logic              cfg_ready;
	logic              cfg_index = CFG_CLICK;
	logic [R_W-1:0]    cfg_data = 0;

	track_scoreboard tracker = new();

	// Receiver behaviour: long hold-off when set, else random stalls per transfer.
	bit sink_hold = 0;
	bit sink_idle_off = 0;
	int items_sent = 0;
	int frames_sent = 0;

	// Centres of the current synthetic blobs, moved a little every frame.
	int blob_cx [6], blob_cy [6];

	always #4 clk = ~clk;

	blob_track_click_drag_classifier_core dut (.*);

	// Hold valid until the transfer is taken; drop it only when idling follows.
	task automatic send_item(bit [1:0] cmd, bit [15:0] px, bit [15:0] py, bit [7:0] c,
		bit idle_ok = 1);
		int gap;
		gap = idle_ok ? $urandom_range(0, 18) : 0;
		if (gap != 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		command <= cmd; point_x <= px; point_y <= py; blob_class <= c;
		in_valid <= 1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		tracker.note_input(cmd, px, py, c);
		items_sent++;
		if (cmd == CMD_END)
			frames_sent++;
	endtask

	// Wait out every pending report, then the block's own wind-down.
	task automatic drain();
		in_valid <= 0;
		while (tracker.pending_reports.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(bit idx, bit [16:0] data);
		cfg_index <= idx; cfg_data <= data; cfg_valid <= 1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		tracker.note_config(idx, data);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	// One frame, at times with a stray random command: blobs jitter or slide, some vanish, some appear.
	task automatic random_frame(int step);
		int nb;
		send_item(CMD_START, $urandom, $urandom, $urandom);
		nb = $urandom_range(0, 5);
		for (int b = 0; b <= nb; b++) begin
			blob_cx[b] += $urandom_range(0, 2 * step) - step;
			blob_cy[b] += $urandom_range(0, 2 * step) - step;
			if ($urandom_range(0, 19) == 0) begin
				blob_cx[b] = $urandom; blob_cy[b] = $urandom;
			end
			if (blob_cx[b] < 0) blob_cx[b] = 0;
			if (blob_cx[b] > 65535) blob_cx[b] = 65535;
			if (blob_cy[b] < 0) blob_cy[b] = 0;
			if (blob_cy[b] > 65535) blob_cy[b] = 65535;
			send_item(CMD_POINT, blob_cx[b], blob_cy[b], $urandom);
		end
		if ($urandom_range(0, 9) == 0)
			send_item($urandom_range(0, 3), $urandom, $urandom, $urandom);
		send_item(CMD_END, $urandom, $urandom, $urandom);
	endtask

	// Receiver: one sampling process, stalls drawn per transfer.
	initial begin : sink
		int stall;
		@(posedge arst_n);
		forever begin
			stall = sink_idle_off ? 0 : $urandom_range(0, 18);
			if (stall != 0 || sink_hold) begin
				out_ready <= 0;
				repeat (stall) @(posedge clk);
				while (sink_hold) @(posedge clk);
			end
			out_ready <= 1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			tracker.check_report('{present, last, track_id, event_kind, current_x,
				current_y, start_x, start_y, track_class, track_confidence});
		end
	end

	initial begin : stimulus
		bit [16:0] radii [4][2];
		radii = '{'{17'd4588, 17'd9830}, '{17'd0, 17'd65536},
			'{17'd65536, 17'd65536}, '{17'd300, 17'd2000}};
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: empty frame, field extremes, odd commands, exact radius.
		send_item(CMD_END, 0, 0, 0);
		send_item(3, 16'hFFFF, 16'hFFFF, 8'hFF);
		for (int f = 0; f < 6; f++) begin
			send_item(CMD_START, 0, 0, 0);
			send_item(CMD_POINT, 0, 0, 8'h00);
			send_item(CMD_POINT, 16'hFFFF, 16'hFFFF, 8'hFF);
			// exact click radius: unmatched, opens a fresh record
			send_item(CMD_POINT, 16'd4588 * (f == 0), 0, 8'h5A);
			send_item(CMD_END, 0, 0, 0);
		end
		// A point with no frame start and a repeated frame end.
		send_item(CMD_POINT, 16'h8000, 16'h7FFF, 8'hA5);
		send_item(CMD_END, 0, 0, 0);
		send_item(CMD_END, 0, 0, 0);
		drain();

		// Phases over several radius settings; the table fills and empties.
		for (int ph = 0; ph < 4; ph++) begin
			write_reg(CFG_CLICK, radii[ph][0]);
			write_reg(!CFG_CLICK, radii[ph][1]);
			for (int b = 0; b < 6; b++) begin
				blob_cx[b] = $urandom; blob_cy[b] = $urandom;
			end
			sink_idle_off = (ph == 2);
			for (int f = 0; f < 14; f++)
				random_frame(ph == 3 ? 1500 : 4000);
			// Sender pauses until every report is back.
			drain();
		end

		// Table full: many scattered points, then drop points; noise at the end.
		write_reg(CFG_CLICK, 17'd50);
		write_reg(!CFG_CLICK, 17'd60);
		for (int f = 0; f < 6; f++) begin
			send_item(CMD_START, 0, 0, 0);
			for (int p = 0; p < 18; p++)
				send_item(CMD_POINT, $urandom, $urandom, $urandom);
			send_item(CMD_END, 0, 0, 0);
		end

		// Long receiver hold-off while the sender keeps offering frame ends.
		sink_hold = 1;
		fork
			begin
				repeat (400) @(posedge clk);
				sink_hold = 0;
			end
			for (int k = 0; k < 6; k++)
				send_item(CMD_END, 0, 0, 0, 0);
		join
		for (int k = 0; k < 40; k++)
			send_item($urandom_range(0, 3), $urandom, $urandom, $urandom);
		send_item(CMD_END, 0, 0, 0);
		drain();

		$display("Sent %0d items in %0d frames; checked %0d reports over five radius settings.",
			items_sent, frames_sent, tracker.reports_seen);
		if (tracker.errors == 0 && tracker.pending_reports.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin : watchdog
		#20ms;
		$display("Regression FAIL");
		$finish;
	end
endmodule
